FILE: sv/tahm_pkg.sv
// Shared types and codes for the touch area hit mapper.
package tahm_pkg;

  // Item kinds carried on s_tuser
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_DOWN   = 2'd1;
  localparam logic [1:0] KIND_UP     = 2'd2;
  localparam logic [1:0] KIND_OFFSET = 2'd3;

  // Result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_BAD_ID = 1'b1;

  // Panel extent after reset
  localparam logic [11:0] EXTENT_RESET = 12'd1080;

  // Area shapes
  localparam logic SHAPE_CIRCLE = 1'b0;
  localparam logic SHAPE_RECT   = 1'b1;

  // One area table entry
  typedef struct packed {
    logic               shape;
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic        [11:0] width;
    logic        [11:0] height;
    logic signed [12:0] mid_x;
    logic signed [12:0] mid_y;
    logic signed [12:0] shift_x;
    logic signed [12:0] shift_y;
  } area_t;

endpackage

FILE: sv/touch_area_hit_mapper.sv
// Touch area hit mapper: area table, per-slot hit memory and sequential hit scan.
// Load and up go from request straight to the result register; offset first fetches the slot's area entry.
// Down scans areas 1..AREA_COUNT-1 through one shared multiplier and compare:
// each circle area passes the fetch, C0, C1, C2 and C3 states, each rectangle area
// the fetch, C0 and R1 states. One request is in work at a time.
// Reset (rst, synchronous) clears table valid bits, slot table, output valid; extent is 1080.
module touch_area_hit_mapper #(
  parameter int AREA_COUNT  = 32,
  parameter int POINT_SLOTS = 10
) (
  input  logic         clk,
  input  logic         rst,
  // s_tdata: touch_id[3:0], slot_index[8:4], shape_sel[9], coord_x[22:10],
  // coord_y[35:23], size_w[47:36], size_h[59:48], ctr_x[72:60], ctr_y[85:73],
  // shift_x_in[98:86], shift_y_in[111:99]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,
  // s_tuser: kind[1:0]
  input  logic [1:0]   s_tuser,
  // m_tdata: status[0], hit_area[5:1], result_x[20:6], result_y[35:21], zero[39:36]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [11:0]  cfg_wdata
);

  localparam int AIDX = $clog2(AREA_COUNT);
  localparam int PIDX = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
  localparam logic [AIDX-1:0] LAST_AREA  = AIDX'(AREA_COUNT - 1);
  localparam logic [AIDX-1:0] FIRST_AREA = AIDX'(1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FETCH = 4'd1;
  localparam logic [3:0] ST_C0    = 4'd2;
  localparam logic [3:0] ST_C1    = 4'd3;
  localparam logic [3:0] ST_C2    = 4'd4;
  localparam logic [3:0] ST_C3    = 4'd5;
  localparam logic [3:0] ST_R1    = 4'd6;
  localparam logic [3:0] ST_OFS   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  // Input field decode
  logic [1:0]         in_kind;
  logic [3:0]         in_pid;
  logic [4:0]         in_slot;
  logic               in_shape;
  logic signed [12:0] in_cx, in_cy, in_ctrx, in_ctry, in_shx, in_shy;
  logic [11:0]        in_w, in_h;

  assign in_kind  = s_tuser;
  assign in_pid   = s_tdata[3:0];
  assign in_slot  = s_tdata[8:4];
  assign in_shape = s_tdata[9];
  assign in_cx    = $signed(s_tdata[22:10]);
  assign in_cy    = $signed(s_tdata[35:23]);
  assign in_w     = s_tdata[47:36];
  assign in_h     = s_tdata[59:48];
  assign in_ctrx  = $signed(s_tdata[72:60]);
  assign in_ctry  = $signed(s_tdata[85:73]);
  assign in_shx   = $signed(s_tdata[98:86]);
  assign in_shy   = $signed(s_tdata[111:99]);

  // Control and item registers
  logic [3:0]         state;
  logic [AIDX-1:0]    idx;
  logic [1:0]         kind_q;
  logic [PIDX-1:0]    pid_q;
  logic signed [12:0] cx_q, cy_q;
  logic signed [13:0] roty_q;
  logic [11:0]        extent;
  logic [AIDX-1:0]    point_area [POINT_SLOTS];

  // Shared arithmetic unit registers
  logic signed [29:0] mul_q;
  logic [27:0]        acc;
  logic               flag_q;

  // Result registers
  logic               res_status;
  logic [AIDX-1:0]    res_hit;
  logic signed [14:0] res_x, res_y;

  // Handshake and range checks
  logic            accept;
  logic            pid_ok;
  logic [PIDX-1:0] pidx;
  logic [6:0]      slot_wide;
  logic            load_ok;
  logic [AIDX-1:0] load_addr;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign pid_ok    = {1'b0, in_pid} < 5'(POINT_SLOTS);
  assign pidx      = in_pid[PIDX-1:0];
  assign slot_wide = {2'b00, in_slot};
  assign load_ok   = slot_wide < 7'(AREA_COUNT);
  assign load_addr = slot_wide[AIDX-1:0];

  // Area table memory with valid bits standing in for the cleared reset state
  tahm_pkg::area_t     mem [AREA_COUNT];
  tahm_pkg::area_t     rd_q;
  tahm_pkg::area_t     wr_entry;
  tahm_pkg::area_t     ent;
  logic [AREA_COUNT-1:0] valid;
  logic                rd_valid_q;
  logic                mem_we;

  assign mem_we = accept && (in_kind == tahm_pkg::KIND_LOAD) && load_ok;

  always_comb begin
    wr_entry.shape    = in_shape;
    wr_entry.origin_x = in_cx;
    wr_entry.origin_y = in_cy;
    wr_entry.width    = in_w;
    wr_entry.height   = in_h;
    wr_entry.mid_x    = in_ctrx;
    wr_entry.mid_y    = in_ctry;
    wr_entry.shift_x  = in_shx;
    wr_entry.shift_y  = in_shy;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[load_addr] <= wr_entry;
    end
    if (state == ST_FETCH) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid[load_addr] <= 1'b1;
      end
      if (state == ST_FETCH) begin
        rd_valid_q <= valid[idx];
      end
    end
  end

  // Never-written entries read as zero
  assign ent = rd_valid_q ? rd_q : '0;

  // Circle distance terms and shared multiplier operands
  logic signed [14:0] dx, dy, radius;
  logic signed [14:0] mul_a, mul_b;

  assign dx     = $signed({{2{cy_q[12]}}, cy_q}) -
                  $signed({{2{ent.mid_x[12]}}, ent.mid_x});
  assign dy     = $signed({roty_q[13], roty_q}) -
                  $signed({{2{ent.mid_y[12]}}, ent.mid_y});
  assign radius = $signed({4'b0000, ent.width[11:1]});

  always_comb begin
    case (state)
      ST_C0: begin
        mul_a = dx;
        mul_b = dx;
      end
      ST_C1: begin
        mul_a = dy;
        mul_b = dy;
      end
      default: begin
        mul_a = radius;
        mul_b = radius;
      end
    endcase
  end

  // Rectangle bounds, inclusive on both ends
  logic signed [13:0] px, ox, oy, ox_hi, oy_hi;
  logic               rect_x_in, rect_y_in;
  logic               area_hit;

  assign px        = $signed({cy_q[12], cy_q});
  assign ox        = $signed({ent.origin_x[12], ent.origin_x});
  assign oy        = $signed({ent.origin_y[12], ent.origin_y});
  assign ox_hi     = ox + $signed({2'b00, ent.width});
  assign oy_hi     = oy + $signed({2'b00, ent.height});
  assign rect_x_in = (px >= ox) && (px <= ox_hi);
  assign rect_y_in = (roty_q >= oy) && (roty_q <= oy_hi);
  assign area_hit  = (state == ST_C3) ? (acc < mul_q[27:0]) : (flag_q && rect_y_in);

  // Offset arithmetic
  logic signed [14:0] ofs_x, ofs_y;

  assign ofs_x = $signed({{2{cx_q[12]}}, cx_q}) + $signed({3'b000, extent}) -
                 $signed({{2{ent.shift_y[12]}}, ent.shift_y});
  assign ofs_y = $signed({{2{cy_q[12]}}, cy_q}) +
                 $signed({{2{ent.shift_x[12]}}, ent.shift_x});

  logic [6:0] hit_wide;
  assign hit_wide = 7'(res_hit);

  // Sequencer, slot table, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= FIRST_AREA;
      extent     <= tahm_pkg::EXTENT_RESET;
      m_tvalid   <= 1'b0;
      point_area <= '{default: '0};
    end else begin
      // Shared multiplier runs every cycle
      mul_q <= mul_a * mul_b;

      if (cfg_we) begin
        extent <= cfg_wdata;
      end

      // Drop the result once taken
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cx_q       <= in_cx;
            cy_q       <= in_cy;
            roty_q     <= $signed({2'b00, extent}) - $signed({in_cx[12], in_cx});
            pid_q      <= pidx;
            kind_q     <= in_kind;
            res_status <= tahm_pkg::STATUS_OK;
            res_hit    <= '0;
            res_x      <= '0;
            res_y      <= '0;
            state      <= ST_DONE;
            unique case (in_kind)
              tahm_pkg::KIND_LOAD: begin
                state <= ST_DONE;
              end
              tahm_pkg::KIND_DOWN: begin
                if (!pid_ok) begin
                  res_status <= tahm_pkg::STATUS_BAD_ID;
                end else begin
                  idx   <= FIRST_AREA;
                  state <= ST_FETCH;
                end
              end
              tahm_pkg::KIND_UP: begin
                if (!pid_ok) begin
                  res_status <= tahm_pkg::STATUS_BAD_ID;
                end else begin
                  point_area[pidx] <= '0;
                end
              end
              tahm_pkg::KIND_OFFSET: begin
                if (!pid_ok) begin
                  res_status <= tahm_pkg::STATUS_BAD_ID;
                  res_x      <= $signed({{2{in_cx[12]}}, in_cx});
                  res_y      <= $signed({{2{in_cy[12]}}, in_cy});
                end else begin
                  idx   <= point_area[pidx];
                  state <= ST_FETCH;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end

        ST_FETCH: begin
          state <= (kind_q == tahm_pkg::KIND_OFFSET) ? ST_OFS : ST_C0;
        end

        // First test step: rectangle x bounds or circle dx squared
        ST_C0: begin
          if (ent.shape == tahm_pkg::SHAPE_RECT) begin
            flag_q <= rect_x_in;
            state  <= ST_R1;
          end else begin
            state <= ST_C1;
          end
        end

        ST_C1: begin
          acc   <= mul_q[27:0];
          state <= ST_C2;
        end

        ST_C2: begin
          acc   <= acc + mul_q[27:0];
          state <= ST_C3;
        end

        // Decide on this area and advance the scan
        ST_C3, ST_R1: begin
          if (area_hit) begin
            res_hit           <= idx;
            point_area[pid_q] <= idx;
            state             <= ST_DONE;
          end else if (idx == LAST_AREA) begin
            res_hit           <= '0;
            point_area[pid_q] <= '0;
            state             <= ST_DONE;
          end else begin
            idx   <= idx + FIRST_AREA;
            state <= ST_FETCH;
          end
        end

        ST_OFS: begin
          res_hit <= idx;
          res_x   <= ofs_x;
          res_y   <= ofs_y;
          state   <= ST_DONE;
        end

        // Hold the result until the output register is free
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, res_y, res_x, hit_wide[4:0], res_status};
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
